// File: rtl/core/greedy_rect_merge_assert.svh
// Assertion macros shared by the greedy rectangle merge RTL.
`ifndef GREEDY_RECT_MERGE_ASSERT_SVH
`define GREEDY_RECT_MERGE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GRM_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/grm_pkg.sv
`default_nettype none
package grm_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int GRP_SIZE = 8;
   localparam int GRP_W    = $clog2(GRP_SIZE);
   localparam int NGRP     = MAX_COLS / GRP_SIZE;
   localparam int NGRP_W   = $clog2(NGRP);

   localparam logic [1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_PULL = 1'b1;

   typedef logic [MAX_COLS-1:0] row_word_type;

   typedef struct packed {
      logic       func;
      logic [5:0] cell_col;
      logic [5:0] cell_row;
      logic       cell_solid;
   } req_type;

   typedef struct packed {
      logic [5:0] rect_col;
      logic [5:0] rect_row;
      logic [6:0] rect_width;
      logic [6:0] rect_height;
      logic       scan_done;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] addr;
      row_word_type     data;
   } wr_port_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] addr;
   } rd_port_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FIND_A,
      ST_FIND_B,
      ST_WIDTH_A,
      ST_WIDTH_B,
      ST_GROW,
      ST_EMIT
   } state_type;

   // bits below n set; n may equal MAX_COLS
   function automatic row_word_type lo_mask(input logic [COL_W:0] n);
      row_word_type ones;
      ones = '1;
      if (n[COL_W]) begin
         return ones;
      end
      return ~(ones << n[COL_W-1:0]);
   endfunction

   function automatic logic [NGRP-1:0] group_any(input row_word_type w);
      logic [NGRP-1:0] g;
      for (int i = 0; i < NGRP; i++) begin
         g[i] = |w[i*GRP_SIZE +: GRP_SIZE];
      end
      return g;
   endfunction

   function automatic logic [GRP_W-1:0] first8(input logic [GRP_SIZE-1:0] v);
      logic [GRP_W-1:0] p;
      p = '0;
      for (int i = GRP_SIZE - 1; i >= 0; i--) begin
         if (v[i]) begin
            p = GRP_W'(i);
         end
      end
      return p;
   endfunction

   function automatic logic [NGRP_W-1:0] first_grp(input logic [NGRP-1:0] v);
      logic [NGRP_W-1:0] p;
      p = '0;
      for (int i = NGRP - 1; i >= 0; i--) begin
         if (v[i]) begin
            p = NGRP_W'(i);
         end
      end
      return p;
   endfunction

   // lowest set bit from registered word and group flags
   function automatic logic [COL_W-1:0] pick_first(input row_word_type w,
                                                   input logic [NGRP-1:0] g);
      logic [NGRP_W-1:0]   gi;
      logic [GRP_SIZE-1:0] bits;
      gi   = first_grp(g);
      bits = w[gi*GRP_SIZE +: GRP_SIZE];
      return {gi, first8(bits)};
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/grm_row_store.sv
`default_nettype none
`include "greedy_rect_merge_assert.svh"
module grm_row_store (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire grm_pkg::wr_port_type  wr,
   input  wire grm_pkg::rd_port_type  rd,
   output      grm_pkg::row_word_type rd_data
);
   import grm_pkg::*;

   row_word_type          mem [MAX_ROWS];
   logic [MAX_ROWS-1:0]   valid_ff;
   logic                  rd_valid_ff;
   row_word_type          rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   // rows never written read as clear
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            rd_valid_ff <= valid_ff[rd.addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

   `GRM_ASSERT(a_no_rw_same_row, clock, reset, wr.en && rd.en, wr.addr != rd.addr, "read and write hit one row")

endmodule
`default_nettype wire

// File: rtl/core/greedy_rect_merge.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | req_data  (func, cell_col, cell_row, cell_solid)
// rsp     | out       | rsp_valid/rsp_stall | rsp_data  (rect_col/row/width/height, scan_done)
// csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// Load beat: one row read-modify-write, skipped when cell_solid is clear.
// Pull beat: ST_FIND_A/ST_FIND_B per row scanned, ST_WIDTH_A, ST_WIDTH_B, ST_GROW per row
// probed below the top, then ST_EMIT, held while an earlier result still waits on rsp_stall.
// Reset is synchronous; row valid flags clear the whole bitmap at once.
// One beat at a time: req_stall is high outside idle and while a csr write is offered.
// A finished rectangle waits in the output register; loads go on meanwhile.
`default_nettype none
`include "greedy_rect_merge_assert.svh"
module greedy_rect_merge (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire grm_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      grm_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [6:0]       csr_wdata
);
   import grm_pkg::*;

   state_type        state_ff, state_in;
   logic [6:0]       scan_row_ff, scan_row_in;
   logic [6:0]       scan_col_ff, scan_col_in;
   logic [6:0]       cols_ff, cols_in;
   logic [6:0]       rows_ff, rows_in;
   logic [6:0]       cur_row_ff, cur_row_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [6:0]       height_ff, height_in;
   logic [6:0]       width_ff, width_in;
   logic             done_ff, done_in;
   row_word_type     row_ff, row_in;
   row_word_type     srch_ff, srch_in;
   row_word_type     span_ff, span_in;
   logic [NGRP-1:0]  grp_ff, grp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   wr_port_type      wr;
   rd_port_type      rd;
   row_word_type     rd_row;

   logic             req_acc;
   logic             csr_acc;
   logic [6:0]       csr_sat;
   logic [6:0]       next_row;
   logic [6:0]       run_end;
   row_word_type     span_c;
   row_word_type     win;

   grm_row_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_row)
   );

   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_acc   = csr_valid && csr_ready;
   assign csr_sat   = (csr_wdata > 7'(MAX_COLS)) ? 7'(MAX_COLS) : csr_wdata;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign win       = lo_mask(cols_ff);
   assign next_row  = cur_row_ff + height_ff;
   assign run_end   = (grp_ff == '0) ? 7'(MAX_COLS) : {1'b0, pick_first(srch_ff, grp_ff)};
   assign span_c    = ~lo_mask({1'b0, cur_col_ff}) & lo_mask(run_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_row_ff  <= '0;
         scan_col_ff  <= '0;
         cols_ff      <= 7'(MAX_COLS);
         rows_ff      <= 7'(MAX_ROWS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_row_ff  <= scan_row_in;
         scan_col_ff  <= scan_col_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_row_ff <= cur_row_in;
      cur_col_ff <= cur_col_in;
      height_ff  <= height_in;
      width_ff   <= width_in;
      done_ff    <= done_in;
      row_ff     <= row_in;
      srch_ff    <= srch_in;
      span_ff    <= span_in;
      grp_ff     <= grp_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      scan_row_in  = scan_row_ff;
      scan_col_in  = scan_col_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      height_in    = height_ff;
      width_in     = width_ff;
      done_in      = done_ff;
      row_in       = row_ff;
      srch_in      = srch_ff;
      span_in      = span_ff;
      grp_in       = grp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr           = '0;
      rd           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cur_col_in = req_data.cell_col;
               cur_row_in = {1'b0, req_data.cell_row};
               done_in    = 1'b0;
               if (req_data.func == FUNC_LOAD) begin
                  scan_row_in = '0;
                  scan_col_in = '0;
                  if (req_data.cell_solid) begin
                     rd.en    = 1'b1;
                     rd.addr  = req_data.cell_row;
                     state_in = ST_LOAD;
                  end
               end else if (scan_row_ff >= rows_ff) begin
                  done_in  = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  cur_row_in = scan_row_ff;
                  cur_col_in = scan_col_ff[COL_W-1:0];
                  rd.en      = 1'b1;
                  rd.addr    = scan_row_ff[ROW_W-1:0];
                  state_in   = ST_FIND_A;
               end
            end
         end
         ST_LOAD: begin
            wr.en    = 1'b1;
            wr.addr  = cur_row_ff[ROW_W-1:0];
            wr.data  = rd_row | (row_word_type'(1) << cur_col_ff);
            state_in = ST_IDLE;
         end
         ST_FIND_A: begin
            row_in   = rd_row;
            srch_in  = rd_row & ~lo_mask({1'b0, cur_col_ff}) & win;
            grp_in   = group_any(srch_in);
            state_in = ST_FIND_B;
         end
         ST_FIND_B: begin
            if (grp_ff == '0) begin
               if (cur_row_ff + 7'd1 >= rows_ff) begin
                  done_in  = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  cur_row_in = cur_row_ff + 7'd1;
                  cur_col_in = '0;
                  rd.en      = 1'b1;
                  rd.addr    = cur_row_in[ROW_W-1:0];
                  state_in   = ST_FIND_A;
               end
            end else begin
               cur_col_in = pick_first(srch_ff, grp_ff);
               state_in   = ST_WIDTH_A;
            end
         end
         ST_WIDTH_A: begin
            // first clear cell at or after the start column
            srch_in  = ~(row_ff & win) & ~lo_mask({1'b0, cur_col_ff});
            grp_in   = group_any(srch_in);
            state_in = ST_WIDTH_B;
         end
         ST_WIDTH_B: begin
            span_in   = span_c;
            width_in  = run_end - {1'b0, cur_col_ff};
            height_in = 7'd1;
            wr.en     = 1'b1;
            wr.addr   = cur_row_ff[ROW_W-1:0];
            wr.data   = row_ff & ~span_c;
            if (cur_row_ff + 7'd1 < rows_ff) begin
               rd.en    = 1'b1;
               rd.addr  = ROW_W'(cur_row_ff + 7'd1);
               state_in = ST_GROW;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_GROW: begin
            if ((rd_row & span_ff) == span_ff) begin
               wr.en     = 1'b1;
               wr.addr   = next_row[ROW_W-1:0];
               wr.data   = rd_row & ~span_ff;
               height_in = height_ff + 7'd1;
               if (next_row + 7'd1 < rows_ff) begin
                  rd.en   = 1'b1;
                  rd.addr = ROW_W'(next_row + 7'd1);
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (done_ff) begin
                  rsp_in           = '0;
                  rsp_in.scan_done = 1'b1;
                  scan_row_in      = '0;
                  scan_col_in      = '0;
               end else begin
                  rsp_in.rect_col    = cur_col_ff;
                  rsp_in.rect_row    = cur_row_ff[ROW_W-1:0];
                  rsp_in.rect_width  = width_ff;
                  rsp_in.rect_height = height_ff;
                  rsp_in.scan_done   = 1'b0;
                  scan_row_in        = cur_row_ff;
                  scan_col_in        = {1'b0, cur_col_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_acc) begin
         priority if (csr_index == CSR_MAP_WIDTH) begin
            cols_in     = csr_sat;
            scan_row_in = '0;
            scan_col_in = '0;
         end else if (csr_index == CSR_MAP_HEIGHT) begin
            rows_in     = (csr_wdata > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : csr_wdata;
            scan_row_in = '0;
            scan_col_in = '0;
         end else begin
            cols_in = cols_ff;
         end
      end
   end

   `GRM_ASSERT(a_grow_in_window, clock, reset, state_ff == ST_GROW, next_row < rows_ff, "row growth left the window")
   `GRM_ASSERT(a_rect_not_empty, clock, reset, rsp_valid_ff && !rsp_ff.scan_done, (rsp_ff.rect_width != 7'd0) && (rsp_ff.rect_height != 7'd0), "empty rectangle emitted")
   `GRM_ASSERT_NEXT(a_load_restarts, clock, reset, req_acc && (req_data.func == FUNC_LOAD), (scan_row_ff == 7'd0) && (scan_col_ff == 7'd0), "load left scan position")
   `GRM_ASSERT(a_width_fits, clock, reset, state_ff == ST_GROW, ({1'b0, cur_col_ff} + width_ff) <= cols_ff, "rectangle wider than window")

endmodule
`default_nettype wire

// File: dv/greedy_rect_merge_tb.sv
`default_nettype none
module greedy_rect_merge_tb;
   import grm_pkg::*;

   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 330;
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [6:0] csr_wdata = '0;

   // predictor state
   logic [MAX_COLS-1:0] tile_solid [MAX_ROWS];
   int unsigned scan_r, scan_c;
   logic [6:0]  map_w, map_h;
   rsp_type     pending_rects [$];
   bit          last_done;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int mismatches   = 0;
   int idle_cycles  = 0;
   int n_loads = 0, n_pulls = 0, n_rects = 0, n_done = 0, n_csr = 0;

   greedy_rect_merge dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int lesser(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic void check_field(string name, logic [6:0] want_v, logic [6:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch %s: expected %0d, got %0d", name, want_v, got_v);
         end
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rects.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result beat: %p", rsp_data);
            end
         end else begin
            want = pending_rects.pop_front();
            check_field("rect_col", 7'(want.rect_col), 7'(rsp_data.rect_col));
            check_field("rect_row", 7'(want.rect_row), 7'(rsp_data.rect_row));
            check_field("rect_width", want.rect_width, rsp_data.rect_width);
            check_field("rect_height", want.rect_height, rsp_data.rect_height);
            check_field("scan_done", 7'(want.scan_done), 7'(rsp_data.scan_done));
            if (want.scan_done) begin
               n_done++;
            end else begin
               n_rects++;
            end
         end
      end
   end

   function automatic void predict_load(req_type item);
      if (item.cell_solid) begin
         tile_solid[item.cell_row][item.cell_col] = 1'b1;
      end
      scan_r = 0;
      scan_c = 0;
   endfunction

   function automatic rsp_type cover_next_rect();
      int unsigned wc, wr, r, c, w, h;
      bit grow, full;
      rsp_type rect;
      wc   = (map_w > MAX_COLS) ? MAX_COLS : map_w;
      wr   = (map_h > MAX_ROWS) ? MAX_ROWS : map_h;
      rect = '0;
      r    = scan_r;
      c    = scan_c;
      while (r < wr && !(c < wc && tile_solid[r][c])) begin
         if (c + 1 < wc) begin
            c++;
         end else begin
            r++;
            c = 0;
         end
      end
      if (r >= wr) begin
         scan_r = 0;
         scan_c = 0;
         rect.scan_done = 1'b1;
         return rect;
      end
      w = 0;
      while (c + w < wc && tile_solid[r][c + w]) w++;
      h    = 1;
      grow = 1'b1;
      while (grow && r + h < wr) begin
         full = 1'b1;
         for (int i = 0; i < w; i++) full &= tile_solid[r + h][c + i];
         if (full) begin
            h++;
         end else begin
            grow = 1'b0;
         end
      end
      for (int j = 0; j < h; j++) begin
         for (int i = 0; i < w; i++) tile_solid[r + j][c + i] = 1'b0;
      end
      scan_r           = r;
      scan_c           = c;
      rect.rect_col    = 6'(c);
      rect.rect_row    = 6'(r);
      rect.rect_width  = 7'(w);
      rect.rect_height = 7'(h);
      return rect;
   endfunction

   function automatic req_type load_item(int col, int row, bit solid);
      req_type item;
      item.func       = FUNC_LOAD;
      item.cell_col   = 6'(col);
      item.cell_row   = 6'(row);
      item.cell_solid = solid;
      return item;
   endfunction

   // cell fields are don't-care on a pull; fill them with noise
   function automatic req_type pull_item();
      req_type item;
      item.func       = FUNC_PULL;
      item.cell_col   = 6'($urandom_range(63));
      item.cell_row   = 6'($urandom_range(63));
      item.cell_solid = 1'($urandom_range(1));
      return item;
   endfunction

   task automatic send_req(input req_type item);
      int gap;
      rsp_type rect;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (item.func == FUNC_LOAD) begin
         predict_load(item);
         n_loads++;
      end else begin
         rect = cover_next_rect();
         pending_rects = {pending_rects, rect};
         last_done = rect.scan_done;
         n_pulls++;
      end
      gap = 0;
      while (gap < 20 && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic pull_until_done();
      do send_req(pull_item()); while (!last_done);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [6:0] val);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_MAP_WIDTH) begin
         map_w = val;
      end else if (idx == CSR_MAP_HEIGHT) begin
         map_h = val;
      end
      if (idx == CSR_MAP_WIDTH || idx == CSR_MAP_HEIGHT) begin
         scan_r = 0;
         scan_c = 0;
      end
      n_csr++;
   endtask

   function automatic logic [6:0] pick_dim();
      case ($urandom_range(11))
         0: begin
            return 7'd0;
         end
         1: begin
            return 7'd1;
         end
         2, 3: begin
            return 7'd64;
         end
         4: begin
            return 7'($urandom_range(65, 127));
         end
         default: begin
            return 7'($urandom_range(2, 16));
         end
      endcase
   endfunction

   // empty map, the four corners, a non-solid load
   task automatic test_corners();
      send_req(pull_item());
      send_req(load_item(0, 0, 1'b1));
      send_req(load_item(63, 0, 1'b1));
      send_req(load_item(0, 63, 1'b1));
      send_req(load_item(63, 63, 1'b1));
      send_req(load_item(20, 20, 1'b0));
      pull_until_done();
   endtask

   // a load behind the scan position must still be covered
   task automatic test_scan_restart();
      send_req(load_item(5, 0, 1'b1));
      send_req(load_item(0, 1, 1'b1));
      send_req(pull_item());
      send_req(load_item(1, 0, 1'b1));
      pull_until_done();
   endtask

   task automatic test_block();
      for (int r = 2; r < 4; r++) begin
         for (int c = 1; c < 4; c++) send_req(load_item(c, r, 1'b1));
      end
      pull_until_done();
   endtask

   // tiny, saturated and empty windows; cells outside the window are kept
   task automatic test_window();
      write_csr(CSR_MAP_WIDTH, 7'd1);
      write_csr(CSR_MAP_HEIGHT, 7'd1);
      send_req(load_item(0, 0, 1'b1));
      send_req(load_item(5, 5, 1'b1));
      pull_until_done();
      write_csr(CSR_MAP_WIDTH, 7'd127);
      write_csr(CSR_MAP_HEIGHT, 7'd65);
      pull_until_done();
      write_csr(CSR_MAP_WIDTH, 7'd0);
      send_req(load_item(0, 0, 1'b1));
      pull_until_done();
      write_csr(CSR_SPARE_2, 7'($urandom_range(127)));
      write_csr(CSR_SPARE_3, 7'($urandom_range(127)));
      write_csr(CSR_MAP_WIDTH, 7'd64);
      write_csr(CSR_MAP_HEIGHT, 7'd64);
      pull_until_done();
   endtask

   task automatic cover_batch();
      int span_c, span_r, kind, sw, sh, x0, y0;
      span_c = (map_w == 0) ? MAX_COLS : lesser(map_w, MAX_COLS);
      span_r = (map_h == 0) ? MAX_ROWS : lesser(map_h, MAX_ROWS);
      repeat ($urandom_range(1, 3)) begin
         kind = $urandom_range(15);
         if (kind == 0) begin
            sw = span_c;
            sh = $urandom_range(1, lesser(span_r, 2));
         end else if (kind == 1) begin
            sw = 1;
            sh = span_r;
         end else begin
            sw = $urandom_range(1, lesser(span_c, 5));
            sh = $urandom_range(1, lesser(span_r, 5));
         end
         x0 = $urandom_range(0, span_c - sw);
         y0 = $urandom_range(0, span_r - sh);
         for (int j = 0; j < sh; j++) begin
            for (int i = 0; i < sw; i++) begin
               send_req(load_item(x0 + i, y0 + j, $urandom_range(9) != 0));
            end
         end
      end
      repeat ($urandom_range(0, 4)) begin
         send_req(load_item($urandom_range(63), $urandom_range(63), 1'($urandom_range(1))));
      end
      if ($urandom_range(19) == 0) begin
         repeat ($urandom_range(1, 2)) send_req(pull_item());
      end else begin
         do begin
            if ($urandom_range(15) == 0) begin
               send_req(load_item($urandom_range(span_c - 1), $urandom_range(span_r - 1),
                                  1'($urandom_range(1))));
            end
            send_req(pull_item());
         end while (!last_done);
      end
   endtask

   task automatic test_random(input int req_pct, input int rsp_pct, input int n_items);
      int start;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      start = n_loads + n_pulls;
      while (n_loads + n_pulls - start < n_items) begin
         if ($urandom_range(9) < 3) begin
            write_csr(CSR_MAP_WIDTH, pick_dim());
            write_csr(CSR_MAP_HEIGHT, pick_dim());
            if ($urandom_range(7) == 0) begin
               write_csr($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3,
                         7'($urandom_range(127)));
            end
         end
         cover_batch();
      end
      settle();
   endtask

   initial begin
      for (int i = 0; i < MAX_ROWS; i++) tile_solid[i] = '0;
      scan_r = 0;
      scan_c = 0;
      map_w  = 7'd64;
      map_h  = 7'd64;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 35;
      rsp_idle_pct = 66;
      test_corners();
      test_scan_restart();
      test_block();
      test_window();
      test_random(35, 66, RANDOM_ITEMS);
      test_random(66, 35, RANDOM_ITEMS);
      test_random(0, 0, RANDOM_ITEMS);
      settle();
      if (pending_rects.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", pending_rects.size());
      end
      $display("run: %0d loads, %0d pulls, %0d rectangles, %0d empty answers, %0d csr writes",
               n_loads, n_pulls, n_rects, n_done, n_csr);
      $display("windows from empty to saturated, sender/receiver idling 35/66, 66/35, none");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/grm_pkg.sv
rtl/core/grm_row_store.sv
rtl/core/greedy_rect_merge.sv
dv/greedy_rect_merge_tb.sv
